>>> sv/rgbhsv_pkg.sv
// rgbhsv_pkg: types, widths and constants shared by the rgb to hsv converter
// no dependencies; every other file of the block refers to it by scoped names

package rgbhsv_pkg;

  localparam int CH_W      = 8;            // one colour channel
  localparam int HUE_W     = 9;            // hue in degrees, 0..359
  localparam int NUM_W     = 2 * CH_W;     // dividend of either division
  localparam int DIV_CELLS = CH_W;         // one quotient bit per cell
  localparam int IN_W      = 3 * CH_W;
  localparam int OUT_W     = 32;           // 25 payload bits padded to bytes
  localparam int HS_W      = HUE_W + 2;    // signed working width for hue

  localparam logic [HUE_W-1:0] BASE_RED   = 9'd0;
  localparam logic [HUE_W-1:0] BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] BASE_BLUE  = 9'd240;
  localparam logic [HS_W-1:0]  HUE_WRAP   = 11'd360;

  // one restoring division in flight: remainder, then dividend bits that are
  // shifted out at the top while quotient bits come in at the bottom
  typedef struct packed {
    logic [CH_W-1:0] den;
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] work;
  } div_t;

  typedef struct packed {
    div_t             sat;
    div_t             hue;
    logic             neg;
    logic [HUE_W-1:0] base;
    logic [CH_W-1:0]  val;
  } pix_t;

endpackage

>>> sv/rgbhsv_prep.sv
// rgbhsv_prep: first pipeline stage, max/min/delta, sector and dividends
// depends on rgbhsv_pkg

module rgbhsv_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgbhsv_pkg::IN_W-1:0] in_data,   // red, green, blue from bit 0 up
  output logic                        out_valid,
  input  logic                        out_ready,
  output rgbhsv_pkg::pix_t            out_data
);

  logic [7:0]       r, g, b;
  logic [7:0]       mx, mn, delta, absd;
  logic [8:0]       diff;
  logic [15:0]      sat_num, hue_num;
  logic [13:0]      hue_prod;
  logic             load;
  rgbhsv_pkg::pix_t nxt;

  assign r = in_data[7:0];
  assign g = in_data[15:8];
  assign b = in_data[23:16];

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;

    if (r == mx) begin
      diff     = {1'b0, g} - {1'b0, b};
      nxt.base = rgbhsv_pkg::BASE_RED;
    end else if (g == mx) begin
      diff     = {1'b0, b} - {1'b0, r};
      nxt.base = rgbhsv_pkg::BASE_GREEN;
    end else begin
      diff     = {1'b0, r} - {1'b0, g};
      nxt.base = rgbhsv_pkg::BASE_BLUE;
    end
    nxt.neg = diff[8];
    absd    = diff[8] ? 8'(-diff) : diff[7:0];

    // delta*255 and |diff|*60 by shift and subtract
    sat_num  = {delta, 8'd0} - {8'd0, delta};
    hue_prod = {absd, 6'd0} - {4'd0, absd, 2'd0};
    hue_num  = {2'b00, hue_prod};

    // black or grey pixels give a zero dividend; divide by one instead of zero
    nxt.sat.den  = (mx == 8'd0) ? 8'd1 : mx;
    nxt.sat.rem  = sat_num[15:8];
    nxt.sat.work = sat_num[7:0];
    nxt.hue.den  = (delta == 8'd0) ? 8'd1 : delta;
    nxt.hue.rem  = hue_num[15:8];
    nxt.hue.work = hue_num[7:0];
    nxt.val      = mx;
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

>>> sv/rgbhsv_cell.sv
// rgbhsv_cell: one restoring division step for saturation and hue, registered
// depends on rgbhsv_pkg

module rgbhsv_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rgbhsv_pkg::pix_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rgbhsv_pkg::pix_t out_data
);

  function automatic rgbhsv_pkg::div_t div_step(input rgbhsv_pkg::div_t d);
    logic [8:0]         t;
    logic [8:0]         s;
    logic               ge;
    rgbhsv_pkg::div_t   o;
    t      = {d.rem, d.work[7]};
    s      = t - {1'b0, d.den};
    ge     = (t >= {1'b0, d.den});
    o.den  = d.den;
    o.rem  = ge ? s[7:0] : t[7:0];
    o.work = {d.work[6:0], ge};
    return o;
  endfunction

  logic             load;
  rgbhsv_pkg::pix_t nxt;

  always_comb begin
    nxt     = in_data;
    nxt.sat = div_step(in_data.sat);
    nxt.hue = div_step(in_data.hue);
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

>>> sv/rgbhsv_post.sv
// rgbhsv_post: output stage, hue from sector base and signed quotient
// depends on rgbhsv_pkg

module rgbhsv_post (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rgbhsv_pkg::pix_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgbhsv_pkg::OUT_W-1:0] out_data  // hue_deg, sat_out, val_out from bit 0 up
);

  localparam int HS_W = rgbhsv_pkg::HS_W;

  logic [HS_W-1:0] base_x, q_x, hs, hw;
  logic            remnz;
  logic            load;

  always_comb begin
    base_x = {2'b00, in_data.base};
    q_x    = {3'b000, in_data.hue.work};
    remnz  = |in_data.hue.rem;
    // floor of a negative fraction rounds one further down when inexact
    if (in_data.neg) begin
      hs = base_x - q_x - {{(HS_W-1){1'b0}}, remnz};
    end else begin
      hs = base_x + q_x;
    end
    hw = hs[HS_W-1] ? hs + rgbhsv_pkg::HUE_WRAP : hs;
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= {7'd0, in_data.val, in_data.sat.work, hw[rgbhsv_pkg::HUE_W-1:0]};
    end
  end

endmodule

>>> sv/rgb_to_hsv_converter_top.sv
// rgb_to_hsv_converter_top: stream wrapper chaining prep, division cells and post
// depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_cell, rgbhsv_post

// Converts one 8-bit RGB pixel per clock into hue (0..359 degrees, truncated),
// saturation floor(delta*255/max) and value max; black gives all zeros and grey
// gives hue and saturation zero. From input word to output word the path runs:
// one stage finds max, min and the dividends, eight identical cells each
// produce one quotient bit of both divisions, and one stage forms the hue. Every
// stage holds its word while the next is full, so bubbles close up and the input
// keeps taking words until the whole chain is stalled by the output side.

module rgb_to_hsv_converter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rgbhsv_pkg::IN_W-1:0]  s_tdata,   // red, green, blue from bit 0 up
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rgbhsv_pkg::OUT_W-1:0] m_tdata    // hue_deg, sat_out, val_out, zero pad
);

  localparam int N = rgbhsv_pkg::DIV_CELLS;

  rgbhsv_pkg::pix_t lnk_data  [N+1];
  logic             lnk_valid [N+1];
  logic             lnk_ready [N+1];

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (lnk_valid[0]),
    .out_ready (lnk_ready[0]),
    .out_data  (lnk_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lnk_valid[i]),
      .in_ready  (lnk_ready[i]),
      .in_data   (lnk_data[i]),
      .out_valid (lnk_valid[i+1]),
      .out_ready (lnk_ready[i+1]),
      .out_data  (lnk_data[i+1])
    );
  end

  rgbhsv_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lnk_valid[N]),
    .in_ready  (lnk_ready[N]),
    .in_data   (lnk_data[N]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  // input can only stall when the chain is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output side is free");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] < 9'd360))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[24:17] == 8'd0)) |-> (m_tdata[16:0] == 17'd0))
    else $error("black pixel with nonzero hue or saturation");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:25] == 7'd0))
    else $error("padding bits set");
`endif

endmodule
